@@ hdl/rsnh_pkg.sv @@
// Package for the ray and sphere nearest hit unit.
// Holds the sphere record, the sequencer state type, codes and Q16.16 helpers.
// Used by every module in this folder; depends on nothing else.
`timescale 1ns / 1ps
package rsnh_pkg;

	localparam int MAX_SPHERES = 16;
	localparam int IW = $clog2(MAX_SPHERES);
	localparam int KW = $clog2(MAX_SPHERES) + 1;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_TRACE = 1'b1;

	localparam logic [0:0] REG_SPHERE_COUNT = 1'b0;

	localparam int SQRT_IN_W  = 64;
	localparam int SQRT_OUT_W = 32;
	localparam int DIV_N_W    = 48;
	localparam int DIV_D_W    = 32;

	typedef struct packed {
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] cz;
		logic        [30:0] r;
	} sphere_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_A0, ST_A1, ST_A2, ST_A3,
		ST_O, ST_H0, ST_H1, ST_H2,
		ST_C0, ST_C1, ST_C2, ST_C3,
		ST_Q0, ST_Q1, ST_Q2, ST_SQ, ST_DV, ST_NEXT,
		ST_L0, ST_L1, ST_L2, ST_L3,
		ST_P0, ST_P1, ST_P2, ST_P3,
		ST_LEN, ST_NDIV, ST_NRM, ST_OUT
	} rsnh_state_t;

	// Saturate a 36-bit signed value to 32 bits.
	function automatic logic signed [31:0] sat36(input logic signed [35:0] v);
		if (!v[35] && (|v[34:31])) begin
			return 32'sh7FFF_FFFF;
		end else if (v[35] && !(&v[34:31])) begin
			return 32'sh8000_0000;
		end else begin
			return v[31:0];
		end
	endfunction

	// Q16.16 product: floor of the raw product over 2^16, saturated.
	function automatic logic signed [31:0] mulq(input logic signed [63:0] p);
		logic signed [47:0] sh;
		sh = p[63:16];
		if (!sh[47] && (|sh[46:31])) begin
			return 32'sh7FFF_FFFF;
		end else if (sh[47] && !(&sh[46:31])) begin
			return 32'sh8000_0000;
		end else begin
			return sh[31:0];
		end
	endfunction

endpackage

@@ hdl/rsnh_sphere_cell.sv @@
// One cell of the sphere ring: holds one sphere record.
// Loads from the input side or takes its neighbor's record when the ring turns.
// Depends on rsnh_pkg.
`timescale 1ns / 1ps
module rsnh_sphere_cell
	import rsnh_pkg::*;
(
	input  logic    clk,
	input  logic    load_en,
	input  sphere_t load_data,
	input  logic    shift_en,
	input  sphere_t next_data,
	output sphere_t data
);

	sphere_t data_q;

	always_ff @(posedge clk) begin
		if (load_en) begin
			data_q <= load_data;
		end else if (shift_en) begin
			data_q <= next_data;
		end
	end

	assign data = data_q;

endmodule

@@ hdl/rsnh_isqrt.sv @@
// Iterative integer square root, two radicand bits per cycle.
// Gives floor(sqrt(x)) of a 64-bit value; depends on rsnh_pkg.
`timescale 1ns / 1ps
module rsnh_isqrt
	import rsnh_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [SQRT_IN_W-1:0]  radicand,
	output logic                  busy,
	output logic [SQRT_OUT_W-1:0] root
);

	logic [SQRT_IN_W-1:0]    x_q;
	logic [SQRT_OUT_W+2:0]   rem_q;
	logic [SQRT_OUT_W-1:0]   root_q;
	logic [4:0]              cnt_q;
	logic                    busy_q;
	logic [SQRT_OUT_W+2:0]   rem_sh;
	logic [SQRT_OUT_W+2:0]   trial;
	logic                    ge;

	assign rem_sh = {rem_q[SQRT_OUT_W:0], x_q[SQRT_IN_W-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 5'(SQRT_OUT_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= {x_q[SQRT_IN_W-3:0], 2'b00};
			rem_q  <= ge ? rem_sh - trial : rem_sh;
			root_q <= {root_q[SQRT_OUT_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign root = root_q;

endmodule

@@ hdl/rsnh_divider.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Divides a 48-bit dividend by a 32-bit divisor; depends on rsnh_pkg.
`timescale 1ns / 1ps
module rsnh_divider
	import rsnh_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DIV_N_W-1:0] dividend,
	input  logic [DIV_D_W-1:0] divisor,
	output logic               busy,
	output logic [DIV_N_W-1:0] quotient
);

	logic [DIV_N_W-1:0] quo_q;
	logic [DIV_D_W:0]   rem_q;
	logic [DIV_D_W-1:0] div_q;
	logic [5:0]         cnt_q;
	logic               busy_q;
	logic [DIV_D_W:0]   rem_sh;
	logic               ge;

	assign rem_sh = {rem_q[DIV_D_W-1:0], quo_q[DIV_N_W-1]};
	assign ge     = rem_sh >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'(DIV_N_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_N_W-2:0], ge};
			rem_q <= ge ? rem_sh - {1'b0, div_q} : rem_sh;
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

@@ hdl/ray_sphere_nearest_hit_unit.sv @@
// Ray and sphere nearest hit unit, top level. Load beats write one sphere into a ring of
// sixteen cells. A trace beat turns the ring once, one slot per step, and tests each of
// the first sphere_count slots through one shared 32x32 multiplier, a 32-step square-root
// unit and a 48-step divider, after the direction length is formed. A hit then computes
// the normal (one root, three divisions). One trace is worked at a time; a finished result
// waits in the output register while the next beat is taken. Depends on rsnh_pkg and the
// cell, root and divider modules.
`timescale 1ns / 1ps
module ray_sphere_nearest_hit_unit
	import rsnh_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// slot, point_x, point_y, point_z, radius, dir_x, dir_y, dir_z; zero fill.
	input  logic [231:0] s_axis_tdata,
	// kind.
	input  logic [0:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// object_index, hit_distance, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z.
	output logic [191:0] m_axis_tdata,
	// hit.
	output logic [0:0]   m_axis_tuser
);

	rsnh_state_t state_q, state_d;

	logic [4:0]          count_q;
	sphere_t             cell_data [MAX_SPHERES];
	sphere_t             head;
	sphere_t             load_sphere;
	logic                accept, load_en, shift_en;
	logic [IW-1:0]       in_slot;

	logic signed [31:0]  p_q [3];
	logic signed [31:0]  d_q [3];
	logic signed [31:0]  o_q [3];
	logic signed [31:0]  bo_q [3];
	logic signed [31:0]  bc_q [3];
	logic signed [31:0]  loc_q [3];
	logic signed [17:0]  nrm_q [3];
	logic signed [31:0]  a_q, h_q, c_q;
	logic signed [35:0]  acc_q;
	logic signed [63:0]  prod_q;
	logic [63:0]         sq_q;
	logic [30:0]         best_q;
	logic [IW-1:0]       best_k_q;
	logic                found_q;
	logic [KW-1:0]       k_q;
	logic [1:0]          nj_q;
	logic [31:0]         len_q;

	logic signed [31:0]  mul_a, mul_b, mq_w, q_w;
	logic                sqrt_start, sqrt_busy, div_start, div_busy;
	logic [63:0]         sqrt_x;
	logic [31:0]         sqrt_root;
	logic [47:0]         div_n, div_quo;
	logic [31:0]         div_d, abs_loc;
	logic [4:0]          n_w;
	logic signed [33:0]  num_w;
	logic                num_pos, q_ok, take, test_slot;
	logic [30:0]         t_w;
	logic [16:0]         nq_w;

	logic                m_valid_q, m_hit_q;
	logic [IW-1:0]       m_idx_q;
	logic [30:0]         m_dist_q;
	logic signed [31:0]  m_pos_q [3];
	logic signed [17:0]  m_nrm_q [3];

	// Configuration port.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (psel && penable && pwrite && (paddr[2] == REG_SPHERE_COUNT)) begin
			count_q <= pwdata[4:0];
		end
	end

	assign prdata = (paddr[2] == REG_SPHERE_COUNT) ? {27'd0, count_q} : 32'd0;

	// Sphere ring.
	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign load_en       = accept && (s_axis_tuser[0] == KIND_LOAD);
	assign shift_en      = (state_q == ST_NEXT);
	assign in_slot       = s_axis_tdata[3:0];
	assign load_sphere   = '{cx: s_axis_tdata[35:4], cy: s_axis_tdata[67:36],
	                         cz: s_axis_tdata[99:68], r: s_axis_tdata[130:100]};

	for (genvar gi = 0; gi < MAX_SPHERES; gi++) begin : g_cell
		rsnh_sphere_cell u_cell (
			.clk       (clk),
			.load_en   (load_en && (in_slot == IW'(gi))),
			.load_data (load_sphere),
			.shift_en  (shift_en),
			.next_data (cell_data[(gi + 1) % MAX_SPHERES]),
			.data      (cell_data[gi])
		);
	end

	assign head = cell_data[0];

	rsnh_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (sqrt_x),
		.busy     (sqrt_busy),
		.root     (sqrt_root)
	);

	rsnh_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_n),
		.divisor  (div_d),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	// Shared combinational terms.
	assign mq_w      = mulq(prod_q);
	assign q_w       = sat36(acc_q - 36'(mq_w));
	assign q_ok      = !q_w[31] && !a_q[31] && (a_q != 32'sd0);
	assign n_w       = (count_q > 5'(MAX_SPHERES)) ? 5'(MAX_SPHERES) : count_q;
	assign test_slot = 5'(k_q) < n_w;
	assign num_w     = -34'(h_q) - $signed({2'b00, sqrt_root});
	assign num_pos   = !num_w[33] && (num_w != 34'sd0);
	assign t_w       = (|div_quo[47:31]) ? 31'h7FFF_FFFF : div_quo[30:0];
	assign take      = (t_w != 31'd0) && (!found_q || (t_w < best_q));
	assign abs_loc   = loc_q[nj_q][31] ? 32'(-loc_q[nj_q]) : 32'(loc_q[nj_q]);
	assign nq_w      = (div_quo > 48'd65536) ? 17'd65536 : div_quo[16:0];

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (s_axis_tuser[0] == KIND_TRACE)) begin
					state_d = ST_A0;
				end
			end
			ST_A0:   state_d = ST_A1;
			ST_A1:   state_d = ST_A2;
			ST_A2:   state_d = ST_A3;
			ST_A3:   state_d = ST_O;
			ST_O:    state_d = test_slot ? ST_H0 : ST_NEXT;
			ST_H0:   state_d = ST_H1;
			ST_H1:   state_d = ST_H2;
			ST_H2:   state_d = ST_C0;
			ST_C0:   state_d = ST_C1;
			ST_C1:   state_d = ST_C2;
			ST_C2:   state_d = ST_C3;
			ST_C3:   state_d = ST_Q0;
			ST_Q0:   state_d = ST_Q1;
			ST_Q1:   state_d = ST_Q2;
			ST_Q2:   state_d = q_ok ? ST_SQ : ST_NEXT;
			ST_SQ: begin
				if (!sqrt_busy) begin
					state_d = num_pos ? ST_DV : ST_NEXT;
				end
			end
			ST_DV: begin
				if (!div_busy) begin
					state_d = ST_NEXT;
				end
			end
			ST_NEXT: begin
				if (k_q == KW'(MAX_SPHERES - 1)) begin
					state_d = found_q ? ST_L0 : ST_OUT;
				end else begin
					state_d = ST_O;
				end
			end
			ST_L0:   state_d = ST_L1;
			ST_L1:   state_d = ST_L2;
			ST_L2:   state_d = ST_L3;
			ST_L3:   state_d = ST_P0;
			ST_P0:   state_d = ST_P1;
			ST_P1:   state_d = ST_P2;
			ST_P2:   state_d = ST_P3;
			ST_P3:   state_d = ST_LEN;
			ST_LEN: begin
				if (!sqrt_busy) begin
					state_d = (sqrt_root == 32'd0) ? ST_OUT : ST_NDIV;
				end
			end
			ST_NDIV: state_d = ST_NRM;
			ST_NRM: begin
				if (!div_busy) begin
					state_d = (nj_q == 2'd2) ? ST_OUT : ST_NDIV;
				end
			end
			ST_OUT: begin
				if (!m_valid_q || m_axis_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: multiplier operands and unit starts.
	always_comb begin
		mul_a      = '0;
		mul_b      = '0;
		sqrt_start = 1'b0;
		sqrt_x     = {16'd0, q_w, 16'd0};
		div_start  = 1'b0;
		div_n      = {num_w[31:0], 16'd0};
		div_d      = a_q;
		unique case (state_q)
			ST_A0:   begin mul_a = d_q[0]; mul_b = d_q[0]; end
			ST_A1:   begin mul_a = d_q[1]; mul_b = d_q[1]; end
			ST_A2:   begin mul_a = d_q[2]; mul_b = d_q[2]; end
			ST_H0:   begin mul_a = o_q[0]; mul_b = d_q[0]; end
			ST_H1:   begin mul_a = o_q[1]; mul_b = d_q[1]; end
			ST_H2:   begin mul_a = o_q[2]; mul_b = d_q[2]; end
			ST_C0:   begin mul_a = o_q[0]; mul_b = o_q[0]; end
			ST_C1:   begin mul_a = o_q[1]; mul_b = o_q[1]; end
			ST_C2:   begin mul_a = o_q[2]; mul_b = o_q[2]; end
			ST_C3: begin
				mul_a = $signed({1'b0, head.r});
				mul_b = $signed({1'b0, head.r});
			end
			ST_Q0:   begin mul_a = h_q; mul_b = h_q; end
			ST_Q1:   begin mul_a = a_q; mul_b = c_q; end
			ST_Q2:   sqrt_start = q_ok;
			ST_SQ:   div_start = !sqrt_busy && num_pos;
			ST_L0:   begin mul_a = d_q[0]; mul_b = $signed({1'b0, best_q}); end
			ST_L1:   begin mul_a = d_q[1]; mul_b = $signed({1'b0, best_q}); end
			ST_L2:   begin mul_a = d_q[2]; mul_b = $signed({1'b0, best_q}); end
			ST_P0:   begin mul_a = loc_q[0]; mul_b = loc_q[0]; end
			ST_P1:   begin mul_a = loc_q[1]; mul_b = loc_q[1]; end
			ST_P2:   begin mul_a = loc_q[2]; mul_b = loc_q[2]; end
			ST_P3: begin
				sqrt_start = 1'b1;
				sqrt_x     = sq_q + prod_q;
			end
			ST_NDIV: begin
				div_start = 1'b1;
				div_n     = {abs_loc, 16'd0};
				div_d     = len_q;
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			found_q <= 1'b0;
			k_q     <= '0;
			nj_q    <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					found_q <= 1'b0;
					k_q     <= '0;
				end
				ST_DV: begin
					if (!div_busy && take) begin
						found_q <= 1'b1;
					end
				end
				ST_NEXT: k_q <= k_q + KW'(1);
				ST_LEN:  nj_q <= '0;
				ST_NRM: begin
					if (!div_busy) begin
						nj_q <= nj_q + 2'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			ST_IDLE: begin
				p_q[0] <= s_axis_tdata[35:4];
				p_q[1] <= s_axis_tdata[67:36];
				p_q[2] <= s_axis_tdata[99:68];
				d_q[0] <= s_axis_tdata[162:131];
				d_q[1] <= s_axis_tdata[194:163];
				d_q[2] <= s_axis_tdata[226:195];
			end
			ST_A1, ST_H1, ST_Q1: acc_q <= 36'(mq_w);
			ST_A2, ST_H2, ST_C1, ST_C2, ST_C3: acc_q <= acc_q + 36'(mq_w);
			ST_A3: a_q <= sat36(acc_q + 36'(mq_w));
			ST_O: begin
				o_q[0] <= sat36(36'(p_q[0]) - 36'(head.cx));
				o_q[1] <= sat36(36'(p_q[1]) - 36'(head.cy));
				o_q[2] <= sat36(36'(p_q[2]) - 36'(head.cz));
			end
			ST_C0: begin
				h_q   <= sat36(acc_q + 36'(mq_w));
				acc_q <= '0;
			end
			ST_Q0: c_q <= sat36(acc_q - 36'(mq_w));
			ST_DV: begin
				if (!div_busy && take) begin
					best_q   <= t_w;
					best_k_q <= k_q[IW-1:0];
					bo_q     <= o_q;
					bc_q[0]  <= head.cx;
					bc_q[1]  <= head.cy;
					bc_q[2]  <= head.cz;
				end
			end
			ST_L1: loc_q[0] <= sat36(36'(bo_q[0]) + 36'(mq_w));
			ST_L2: loc_q[1] <= sat36(36'(bo_q[1]) + 36'(mq_w));
			ST_L3: loc_q[2] <= sat36(36'(bo_q[2]) + 36'(mq_w));
			ST_P1: sq_q <= prod_q;
			ST_P2: sq_q <= sq_q + prod_q;
			ST_LEN: begin
				len_q    <= sqrt_root;
				nrm_q[0] <= '0;
				nrm_q[1] <= '0;
				nrm_q[2] <= '0;
			end
			ST_NRM: begin
				if (!div_busy) begin
					nrm_q[nj_q] <= loc_q[nj_q][31] ? -$signed({1'b0, nq_w})
					                               : $signed({1'b0, nq_w});
				end
			end
			default: begin
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if ((state_q == ST_OUT) && (!m_valid_q || m_axis_tready)) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_OUT) && (!m_valid_q || m_axis_tready)) begin
			m_hit_q  <= found_q;
			m_idx_q  <= found_q ? best_k_q : '0;
			m_dist_q <= found_q ? best_q : '0;
			for (int j = 0; j < 3; j++) begin
				m_pos_q[j] <= found_q ? sat36(36'(loc_q[j]) + 36'(bc_q[j])) : 32'sd0;
				m_nrm_q[j] <= found_q ? nrm_q[j] : 18'sd0;
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_hit_q;
	assign m_axis_tdata  = {7'd0, m_nrm_q[2], m_nrm_q[1], m_nrm_q[0],
	                        m_pos_q[2], m_pos_q[1], m_pos_q[0], m_dist_q, m_idx_q};

endmodule
